### sv/kvi_pkg.sv
// ============================================================================
// Keyframe vertex interpolator package
// Field widths, stream item layouts, operation and status codes, and the
// sequencer state type shared by the interpolator modules.
// ============================================================================
package kvi_pkg;

    localparam int OP_W       = 2;
    localparam int FSEL_W     = 4;
    localparam int COMP_W     = 10;
    localparam int WORD_W     = 16;
    localparam int AMOUNT_W   = 18;
    localparam int VALUE_W    = 16;
    localparam int PHASE_W    = 17;
    localparam int FNOW_W     = 4;
    localparam int STATUS_W   = 2;
    localparam int WEIGHT_W   = 16;
    localparam int DIFF_W     = WORD_W + 1;

    localparam int IN_FIELDS_W  = OP_W + FSEL_W + COMP_W + WORD_W + AMOUNT_W;
    localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = VALUE_W + PHASE_W + FNOW_W + STATUS_W;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

    localparam int FRAMES_CFG_W = 5;
    localparam int VERTS_CFG_W  = 9;
    localparam int CFG_DATA_W   = 9;
    localparam int CFG_INDEX_W  = 1;

    // Phase is Q1.16; 1.0 is the only legal value with bit 16 set.
    localparam logic [PHASE_W-1:0] PHASE_ONE = 17'h1_0000;

    // Shared multiplier operand A carries the phase, the coordinate
    // difference or a frame index.
    localparam int MUL_A_W = 18;

    typedef enum logic [OP_W-1:0] {
        OP_LOAD = 2'd0,
        OP_SET  = 2'd1,
        OP_STEP = 2'd2,
        OP_READ = 2'd3
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_PHASE = 2'd2
    } t_status;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_FRAMES   = 1'b0,
        CFG_VERTICES = 1'b1
    } t_cfg_index;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCALE,
        S_SPLIT,
        S_LD_ADDR,
        S_LD_WRITE,
        S_RD_ADDR_A,
        S_RD_A,
        S_RD_B,
        S_DIFF,
        S_WEIGHT,
        S_SUM,
        S_OUT
    } t_state;

    // Last declared field in the lowest bits.
    typedef struct packed {
        logic signed [AMOUNT_W-1:0] amount;
        logic signed [WORD_W-1:0]   word;
        logic [COMP_W-1:0]          component;
        logic [FSEL_W-1:0]          frame_sel;
        logic [OP_W-1:0]            op;
    } t_in_item;

    typedef struct packed {
        logic [STATUS_W-1:0]       status;
        logic [FNOW_W-1:0]         frame_now;
        logic [PHASE_W-1:0]        phase_now;
        logic signed [VALUE_W-1:0] value;
    } t_out_item;

endpackage

### sv/kvi_ram.sv
// ============================================================================
// Generic single-port RAM
// One read/write port; read data is registered and appears in the cycle after
// the address.
// ============================================================================
module kvi_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end

endmodule

### sv/kvi_mul.sv
// ============================================================================
// Shared signed multiplier
// Registered signed product; the sequencer reuses it for phase scaling,
// keyframe address offsets and the interpolation weight.
// ============================================================================
module kvi_mul #(
    parameter int A_W = 18,
    parameter int B_W = 19
) (
    input  logic                  i_clk,
    input  logic signed [A_W-1:0] i_a,
    input  logic signed [B_W-1:0] i_b,
    output logic signed [A_W+B_W-1:0] o_p
);

    always_ff @(posedge i_clk) begin
        o_p <= i_a * i_b;
    end

endmodule

### sv/keyframe_vertex_interpolator.sv
// ============================================================================
// Keyframe vertex interpolator
// Keyframe store plus animation phase; loads, sets or steps the phase, and
// reads components of the pose linearly interpolated between two keyframes.
// ============================================================================
// One transaction in, one transaction out. The block takes an item only when
// idle and holds its result until it is taken. The steps of each operation
// are set by the single shared multiplier, which is used in turn for the
// scaled phase, each keyframe address (frame times row stride) and the
// weighted difference, and by the one port of the keyframe RAM, which serves
// the two keyframe reads one after the other. Keyframe words are not cleared
// at reset; a read of a word never loaded returns an arbitrary value.
module keyframe_vertex_interpolator #(
    parameter int MAX_FRAMES   = 16,
    parameter int MAX_VERTICES = 256
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // s_axis_tdata from bit 0: op, frame_sel, component, word, amount, zero pad
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [kvi_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    // m_axis_tdata from bit 0: value, phase_now, frame_now, status, zero pad
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [kvi_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    input  logic                             i_cfg_we,
    input  logic [kvi_pkg::CFG_INDEX_W-1:0]  i_cfg_index,
    input  logic [kvi_pkg::CFG_DATA_W-1:0]   i_cfg_wdata
);

    import kvi_pkg::*;

    localparam int NCOMP    = 3 * MAX_VERTICES;
    localparam int DEPTH    = MAX_FRAMES * NCOMP;
    localparam int ADDR_W   = $clog2(DEPTH);
    localparam int STRIDE_W = $clog2(NCOMP + 1);
    localparam int MUL_B_W  = (STRIDE_W + 1 > WEIGHT_W + 1) ? STRIDE_W + 1 : WEIGHT_W + 1;
    localparam int PROD_W   = MUL_A_W + MUL_B_W;
    localparam int SUM_W    = ((ADDR_W > COMP_W) ? ADDR_W : COMP_W) + 1;
    localparam logic [MUL_B_W-1:0] STRIDE = MUL_B_W'(NCOMP);
    // Phase times (frames - 1) stays below 2^(16 + FRAMES_CFG_W).
    localparam int SCALE_HI = WEIGHT_W + FRAMES_CFG_W - 1;

    // Configuration
    logic [FRAMES_CFG_W-1:0] r_frames_cfg;
    logic [VERTS_CFG_W-1:0]  r_verts_cfg;
    logic [FRAMES_CFG_W-1:0] eff_frames;
    logic [FRAMES_CFG_W-1:0] last_frame;
    logic [VERTS_CFG_W-1:0]  eff_verts;
    logic [COMP_W-1:0]       ncomp;

    // Sequencer and item registers
    t_state                    r_state, n_state;
    logic [PHASE_W-1:0]        r_phase, n_phase;
    t_op                       r_op, n_op;
    t_status                   r_status, n_status;
    logic [FSEL_W-1:0]         r_fsel, n_fsel;
    logic [COMP_W-1:0]         r_comp, n_comp;
    logic signed [WORD_W-1:0]  r_word, n_word;
    logic [FRAMES_CFG_W-1:0]   r_lo, n_lo;
    logic [FRAMES_CFG_W-1:0]   r_hi, n_hi;
    logic [WEIGHT_W-1:0]       r_t, n_t;
    logic [FNOW_W-1:0]         r_frame_now, n_frame_now;
    logic signed [WORD_W-1:0]  r_a, n_a;
    logic signed [DIFF_W-1:0]  r_diff, n_diff;
    logic signed [VALUE_W-1:0] r_value, n_value;

    // Datapath
    t_in_item                  in_item;
    t_out_item                 out_item;
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [PROD_W-1:0]  mul_p;
    logic [SUM_W-1:0]          addr_sum;
    logic                      ram_we;
    logic [ADDR_W-1:0]         ram_addr;
    logic [WORD_W-1:0]         ram_rdata;
    logic [FRAMES_CFG_W-1:0]   lo_raw;
    logic [FRAMES_CFG_W-1:0]   lo_clamp;

    assign in_item = t_in_item'(s_axis_tdata[IN_FIELDS_W-1:0]);

    // Out-of-range register values saturate; zero counts as one.
    always_comb begin
        if (r_frames_cfg == '0) begin
            eff_frames = FRAMES_CFG_W'(1);
        end else if (int'(r_frames_cfg) > MAX_FRAMES) begin
            eff_frames = FRAMES_CFG_W'(MAX_FRAMES);
        end else begin
            eff_frames = r_frames_cfg;
        end
        if (r_verts_cfg == '0) begin
            eff_verts = VERTS_CFG_W'(1);
        end else if (int'(r_verts_cfg) > MAX_VERTICES) begin
            eff_verts = VERTS_CFG_W'(MAX_VERTICES);
        end else begin
            eff_verts = r_verts_cfg;
        end
    end

    assign last_frame = eff_frames - FRAMES_CFG_W'(1);
    assign ncomp      = {1'b0, eff_verts} + {eff_verts, 1'b0};

    // Keyframe address: frame * stride from the multiplier, plus component.
    assign addr_sum = SUM_W'(mul_p[ADDR_W-1:0]) + SUM_W'(r_comp);
    assign ram_addr = addr_sum[ADDR_W-1:0];

    assign lo_raw   = mul_p[SCALE_HI:WEIGHT_W];
    assign lo_clamp = (lo_raw > last_frame) ? last_frame : lo_raw;

    always_comb begin
        n_state     = r_state;
        n_phase     = r_phase;
        n_op        = r_op;
        n_status    = r_status;
        n_fsel      = r_fsel;
        n_comp      = r_comp;
        n_word      = r_word;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_t         = r_t;
        n_frame_now = r_frame_now;
        n_a         = r_a;
        n_diff      = r_diff;
        n_value     = r_value;
        mul_a       = '0;
        mul_b       = '0;
        ram_we      = 1'b0;
        s_axis_tready = 1'b0;
        m_axis_tvalid = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid) begin
                    n_op     = t_op'(in_item.op);
                    n_fsel   = in_item.frame_sel;
                    n_comp   = in_item.component;
                    n_word   = in_item.word;
                    n_value  = '0;
                    n_status = ST_OK;
                    unique case (t_op'(in_item.op))
                        OP_LOAD: begin
                            if (({1'b0, in_item.frame_sel} >= eff_frames) ||
                                (in_item.component >= ncomp)) begin
                                n_status = ST_RANGE;
                            end
                        end
                        OP_SET: begin
                            if (in_item.amount[AMOUNT_W-1] ||
                                (in_item.amount[PHASE_W-1:0] > PHASE_ONE)) begin
                                n_status = ST_PHASE;
                            end else begin
                                n_phase = in_item.amount[PHASE_W-1:0];
                            end
                        end
                        OP_STEP: begin
                            // Wrapping into [0,1) keeps only the fraction bits.
                            n_phase = {1'b0, 16'(r_phase[15:0] + in_item.amount[15:0])};
                        end
                        OP_READ: begin
                            if (in_item.component >= ncomp) begin
                                n_status = ST_RANGE;
                            end
                        end
                        default: begin
                            n_status = ST_OK;
                        end
                    endcase
                    n_state = S_SCALE;
                end
            end
            S_SCALE: begin
                mul_a   = {1'b0, r_phase};
                mul_b   = {{(MUL_B_W-FRAMES_CFG_W){1'b0}}, last_frame};
                n_state = S_SPLIT;
            end
            S_SPLIT: begin
                n_lo        = lo_clamp;
                n_hi        = (lo_clamp < last_frame) ? lo_clamp + FRAMES_CFG_W'(1)
                                                      : last_frame;
                n_t         = mul_p[WEIGHT_W-1:0];
                n_frame_now = lo_clamp[FNOW_W-1:0];
                priority if (r_status == ST_OK && r_op == OP_LOAD) begin
                    n_state = S_LD_ADDR;
                end else if (r_status == ST_OK && r_op == OP_READ) begin
                    n_state = S_RD_ADDR_A;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_LD_ADDR: begin
                mul_a   = {{(MUL_A_W-FSEL_W){1'b0}}, r_fsel};
                mul_b   = STRIDE;
                n_state = S_LD_WRITE;
            end
            S_LD_WRITE: begin
                ram_we  = 1'b1;
                n_state = S_OUT;
            end
            S_RD_ADDR_A: begin
                mul_a   = {{(MUL_A_W-FRAMES_CFG_W){1'b0}}, r_lo};
                mul_b   = STRIDE;
                n_state = S_RD_A;
            end
            S_RD_A: begin
                // Lower frame address goes to the RAM; next frame offset starts.
                mul_a   = {{(MUL_A_W-FRAMES_CFG_W){1'b0}}, r_hi};
                mul_b   = STRIDE;
                n_state = S_RD_B;
            end
            S_RD_B: begin
                n_a     = ram_rdata;
                n_state = S_DIFF;
            end
            S_DIFF: begin
                n_diff  = {ram_rdata[WORD_W-1], ram_rdata} - {r_a[WORD_W-1], r_a};
                n_state = S_WEIGHT;
            end
            S_WEIGHT: begin
                mul_a   = {{(MUL_A_W-DIFF_W){r_diff[DIFF_W-1]}}, r_diff};
                mul_b   = {{(MUL_B_W-WEIGHT_W){1'b0}}, r_t};
                n_state = S_SUM;
            end
            S_SUM: begin
                // Arithmetic shift right by 16 is the floor of the division.
                n_value = r_a + mul_p[WEIGHT_W+VALUE_W-1:WEIGHT_W];
                n_state = S_OUT;
            end
            S_OUT: begin
                m_axis_tvalid = 1'b1;
                if (m_axis_tready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_phase <= '0;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op        <= n_op;
        r_status    <= n_status;
        r_fsel      <= n_fsel;
        r_comp      <= n_comp;
        r_word      <= n_word;
        r_lo        <= n_lo;
        r_hi        <= n_hi;
        r_t         <= n_t;
        r_frame_now <= n_frame_now;
        r_a         <= n_a;
        r_diff      <= n_diff;
        r_value     <= n_value;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frames_cfg <= FRAMES_CFG_W'(1);
            r_verts_cfg  <= VERTS_CFG_W'(1);
        end else if (i_cfg_we) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_FRAMES:   r_frames_cfg <= i_cfg_wdata[FRAMES_CFG_W-1:0];
                CFG_VERTICES: r_verts_cfg  <= i_cfg_wdata[VERTS_CFG_W-1:0];
                default:      r_verts_cfg  <= r_verts_cfg;
            endcase
        end
    end

    kvi_mul #(
        .A_W (MUL_A_W),
        .B_W (MUL_B_W)
    ) u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (mul_p)
    );

    kvi_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (r_word),
        .o_rdata (ram_rdata)
    );

    assign out_item.status    = r_status;
    assign out_item.frame_now = r_frame_now;
    assign out_item.phase_now = r_phase;
    assign out_item.value     = r_value;
    assign m_axis_tdata = {{(OUT_TDATA_W-OUT_FIELDS_W){1'b0}}, out_item};

`ifndef ASSERT_OFF
    a_result_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("input ready while a result is pending");

    a_phase_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase <= PHASE_ONE)
        else $error("phase above 1.0");

    a_write_only_good_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (r_op == OP_LOAD && r_status == ST_OK))
        else $error("keyframe write outside a good load");

    a_ready_after_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tready) |=> s_axis_tready)
        else $error("not ready after the result transaction");
`endif

endmodule
